[rtl/free_region_table_allocator_macros.svh]
// assertion macros for the free region table allocator checker
// no dependencies
`ifndef FREE_REGION_TABLE_ALLOCATOR_MACROS_SVH
`define FREE_REGION_TABLE_ALLOCATOR_MACROS_SVH

`define FRAL_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fral assertion failed");

`define FRAL_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fral assertion failed");

`endif

[rtl/fral_pkg.sv]
// shared types and constants of the free region table allocator
// no dependencies
package fral_pkg;

  localparam int SLOTS   = 16;
  localparam int RANK_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam logic [31:0] FLOOR_RESET = 32'h0010_0000;
  localparam logic [2:0]  FLOOR_ADDR  = 3'd0;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_ALLOC = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  typedef struct packed {
    op_t         opcode;
    logic [63:0] region_start;
    logic [63:0] region_size;
    logic [4:0]  align_log2;
  } in_beat_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] alloc_address;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_ADD_CLIP = 3'd1,
    S_ADD_SCAN = 3'd2,
    S_ADD_INS  = 3'd3,
    S_ALC_PREP = 3'd4,
    S_ALC_ST   = 3'd5,
    S_ALC_CHK  = 3'd6,
    S_DONE     = 3'd7
  } state_t;

  typedef struct packed {
    logic load;
    logic clip;
    logic add_scan;
    logic add_ins;
    logic alc_prep;
    logic alc_st;
    logic alc_chk;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic rank_end;
    logic add_hit;
    logic size_zero;
    logic alc_hit;
    logic tail;
    logic out_free;
  } sts_t;

endpackage

[rtl/free_region_table_allocator.sv]
// top level of the free region table allocator
// depends on fral_pkg, fral_ctrl, fral_dp
//
// channel  handshake             payload
// in       in_valid / in_ready   in_data  (in_beat_t)
// out      out_valid / out_ready out_data (out_beat_t)
// cfg      psel penable pwrite   paddr pwdata prdata, pready tied high
//
// clear and unused ops go straight to the result; add clips to the floor, scans
// the entries and inserts when none overlaps; allocate scans the entries, and a
// split tail goes back through the add path
// the single region scan sets how long an item takes; one item at a time
// the next item is taken while a result waits on out
// synchronous active-low reset empties the region list and restores the floor
module free_region_table_allocator import fral_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] floor_q;
  logic        floor_we;

  assign pready   = 1'b1;
  assign floor_we = psel && penable && pwrite && (paddr == FLOOR_ADDR);
  assign prdata   = (paddr == FLOOR_ADDR) ? floor_q : 32'd0;

  fral_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.opcode),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  fral_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_data),
    .floor_we    (floor_we),
    .floor_wdata (pwdata),
    .floor_q     (floor_q),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

[rtl/fral_ctrl.sv]
// controller state machine of the free region table allocator
// depends on fral_pkg
module fral_ctrl import fral_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  op_t  in_op,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_ADD) state_nxt = S_ADD_CLIP;
          else if (in_op == OP_ALLOC) state_nxt = S_ALC_PREP;
          else state_nxt = S_DONE;
        end
      end
      S_ADD_CLIP: state_nxt = sts.skip ? S_DONE : S_ADD_SCAN;
      S_ADD_SCAN: begin
        if (sts.rank_end) state_nxt = S_ADD_INS;
        else if (sts.add_hit) state_nxt = S_DONE;
      end
      S_ADD_INS:  state_nxt = S_DONE;
      S_ALC_PREP: state_nxt = sts.size_zero ? S_DONE : S_ALC_ST;
      S_ALC_ST:   state_nxt = sts.rank_end ? S_DONE : S_ALC_CHK;
      S_ALC_CHK: begin
        if (sts.alc_hit) state_nxt = sts.tail ? S_ADD_CLIP : S_DONE;
        else state_nxt = S_ALC_ST;
      end
      S_DONE:     if (sts.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE:     cmd.load = in_valid;
      S_ADD_CLIP: cmd.clip = 1'b1;
      S_ADD_SCAN: cmd.add_scan = 1'b1;
      S_ADD_INS:  cmd.add_ins = 1'b1;
      S_ALC_PREP: cmd.alc_prep = 1'b1;
      S_ALC_ST:   cmd.alc_st = 1'b1;
      S_ALC_CHK:  cmd.alc_chk = 1'b1;
      S_DONE:     cmd.emit = sts.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

[rtl/fral_dp.sv]
// datapath of the free region table allocator: region list, scan, result register
// depends on fral_pkg
module fral_dp import fral_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  in_beat_t  in_data,
  input  logic      floor_we,
  input  logic [31:0] floor_wdata,
  output logic [31:0] floor_q,
  output sts_t      sts,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic [63:0] base_r [SLOTS];
  logic [63:0] top_r  [SLOTS];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] rank_r;
  logic [63:0] start_r, end_r, size_r, mask_r, st_r, addr_r;
  status_t     status_r;
  logic        tail_r;
  logic [31:0] floor_r;
  logic        out_valid_r;
  out_beat_t   out_data_r;

  logic [RANK_W-1:0] idx;
  logic [63:0] ent_a, ent_t, floor64, stend, sum_in;
  logic c1, c2, c3;

  assign idx     = rank_r[RANK_W-1:0];
  assign ent_a   = base_r[idx];
  assign ent_t   = top_r[idx];
  assign floor64 = {32'd0, floor_r};
  assign stend   = st_r + size_r;
  assign sum_in  = in_data.region_size + 64'd3;
  assign c1 = (start_r >= ent_a) && (start_r <= ent_t);
  assign c2 = (end_r >= ent_a) && (end_r <= ent_t);
  assign c3 = (start_r < ent_a) && (end_r > ent_t);

  always_comb begin
    sts.skip      = (end_r <= floor64);
    sts.rank_end  = (rank_r == count_r);
    sts.add_hit   = c1 || c2 || c3;
    sts.size_zero = (size_r == 64'd0);
    sts.alc_hit   = (st_r >= ent_a) && (stend <= ent_t);
    sts.tail      = (st_r != ent_a) && (stend != ent_t);
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      floor_r     <= FLOOR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (floor_we) floor_r <= floor_wdata;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.load && in_data.opcode == OP_CLEAR) count_r <= '0;
      if (cmd.add_ins && count_r != CNT_W'(SLOTS)) count_r <= count_r + 1'b1;
      if (cmd.alc_chk && sts.alc_hit && st_r == ent_a && stend == ent_t)
        count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_r  <= in_data.region_start;
      end_r    <= in_data.region_start + in_data.region_size;
      size_r   <= {sum_in[63:2], 2'b00};
      mask_r   <= (64'd1 << in_data.align_log2) - 64'd1;
      status_r <= ST_OK;
      addr_r   <= '0;
      tail_r   <= 1'b0;
      rank_r   <= '0;
    end
    if (cmd.clip && start_r < floor64) start_r <= floor64;
    if (cmd.add_scan && !sts.rank_end) begin
      if (c1) begin
        if ((end_r - ent_a) > (ent_t - ent_a)) top_r[idx] <= end_r;
      end else if (c2) begin
        base_r[idx] <= (start_r < ent_a) ? start_r : ent_a;
      end else if (c3) begin
        base_r[idx] <= start_r;
        top_r[idx]  <= end_r;
      end else begin
        rank_r <= rank_r + 1'b1;
      end
    end
    if (cmd.add_ins) begin
      if (count_r == CNT_W'(SLOTS)) begin
        if (!tail_r) status_r <= ST_FULL;
      end else begin
        for (int i = SLOTS - 1; i > 0; i--) begin
          base_r[i] <= base_r[i-1];
          top_r[i]  <= top_r[i-1];
        end
        base_r[0] <= start_r;
        top_r[0]  <= end_r;
      end
    end
    if (cmd.alc_prep && size_r == 64'd0) status_r <= ST_ZERO;
    if (cmd.alc_st) begin
      if (sts.rank_end) status_r <= ST_NOFIT;
      else st_r <= (start_r != 64'd0) ? start_r : ((ent_a + mask_r) & ~mask_r);
    end
    if (cmd.alc_chk) begin
      if (sts.alc_hit) begin
        addr_r <= st_r;
        if (st_r != ent_a) begin
          top_r[idx] <= st_r;
          if (stend != ent_t) begin
            start_r <= stend;
            end_r   <= ent_t;
            tail_r  <= 1'b1;
            rank_r  <= '0;
          end
        end else if (stend != ent_t) begin
          base_r[idx] <= stend;
        end else begin
          for (int i = 0; i < SLOTS - 1; i++) begin
            if (i >= int'(idx)) begin
              base_r[i] <= base_r[i+1];
              top_r[i]  <= top_r[i+1];
            end
          end
        end
      end else begin
        rank_r <= rank_r + 1'b1;
      end
    end
    if (cmd.emit) begin
      out_data_r.status        <= status_r;
      out_data_r.alloc_address <= (status_r == ST_OK) ? addr_r : 64'd0;
    end
  end

  assign floor_q   = floor_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/fral_checker.sv]
// port-level checker for the free region table allocator, with its bind
// depends on fral_pkg and free_region_table_allocator_macros.svh
`include "free_region_table_allocator_macros.svh"

module fral_port_checker import fral_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  `FRAL_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `FRAL_AST_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `FRAL_AST_IMP(a_fail_addr_zero, out_valid && out_data.status != ST_OK, out_data.alloc_address == 64'd0)

endmodule

bind free_region_table_allocator fral_port_checker u_fral_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[dv/fral_checker.sv]
// checker for the free region table allocator: mirrors the region list,
// predicts each result beat and compares it with what the block returns
// depends on fral_pkg
`timescale 1ns / 1ps
module fral_checker import fral_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_beat_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_beat_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);

  logic [63:0] rgn_base [SLOTS];
  logic [63:0] rgn_len  [SLOTS];
  logic        rgn_live [SLOTS];
  int          rgn_rank [SLOTS];
  logic [63:0] floor_q;
  out_beat_t   expected_beats [$];

  assign pending = expected_beats.size();

  function automatic int slot_of_rank(int r);
    for (int i = 0; i < SLOTS; i++)
      if (rgn_live[i] && rgn_rank[i] == r) return i;
    return -1;
  endfunction

  function automatic int live_regions();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (rgn_live[i]) n++;
    return n;
  endfunction

  function automatic status_t merge_region(logic [63:0] start, logic [63:0] len);
    logic [63:0] fin, a, top, ns;
    int n, s, f;
    fin = start + len;
    if (fin <= floor_q) return ST_OK;
    if (start < floor_q) begin
      len = fin - floor_q;
      start = floor_q;
      fin = start + len;
    end
    n = live_regions();
    for (int r = 0; r < n; r++) begin
      s = slot_of_rank(r);
      if (s < 0) continue;
      a = rgn_base[s];
      top = a + rgn_len[s];
      if (start >= a && start <= top) begin
        if (fin - a > rgn_len[s]) rgn_len[s] = fin - a;
        return ST_OK;
      end
      if (fin >= a && fin <= top) begin
        ns = (start < a) ? start : a;
        rgn_len[s] = top - ns;
        rgn_base[s] = ns;
        return ST_OK;
      end
      if (start < a && fin > top) begin
        rgn_base[s] = start;
        rgn_len[s] = len;
        return ST_OK;
      end
    end
    f = -1;
    for (int i = 0; i < SLOTS; i++)
      if (!rgn_live[i] && f < 0) f = i;
    if (f < 0) return ST_FULL;
    for (int i = 0; i < SLOTS; i++) if (rgn_live[i]) rgn_rank[i]++;
    rgn_base[f] = start;
    rgn_len[f] = len;
    rgn_live[f] = 1'b1;
    rgn_rank[f] = 0;
    return ST_OK;
  endfunction

  function automatic out_beat_t carve_region(in_beat_t b);
    out_beat_t res;
    logic [63:0] algn, size, a, top, st, head, tail;
    status_t dummy;
    int n, s, rk;
    res.status = ST_NOFIT;
    res.alloc_address = '0;
    algn = 64'd1 << b.align_log2;
    size = (b.region_size + 64'd3) & ~64'd3;
    if (size == 0) begin
      res.status = ST_ZERO;
      return res;
    end
    n = live_regions();
    for (int r = 0; r < n; r++) begin
      s = slot_of_rank(r);
      if (s < 0) continue;
      a = rgn_base[s];
      top = a + rgn_len[s];
      st = (b.region_start != 0) ? b.region_start : ((a + algn - 1) & ~(algn - 1));
      if (st >= a && st + size <= top) begin
        head = st - a;
        tail = top - (st + size);
        if (head != 0) begin
          rgn_len[s] = head;
          if (tail != 0) dummy = merge_region(st + size, tail);
        end else if (tail != 0) begin
          rgn_base[s] = st + size;
          rgn_len[s] = tail;
        end else begin
          rk = rgn_rank[s];
          rgn_live[s] = 1'b0;
          rgn_rank[s] = 0;
          for (int i = 0; i < SLOTS; i++)
            if (rgn_live[i] && rgn_rank[i] > rk) rgn_rank[i]--;
        end
        res.status = ST_OK;
        res.alloc_address = st;
        return res;
      end
    end
    return res;
  endfunction

  function automatic out_beat_t predict_beat(in_beat_t b);
    out_beat_t res;
    res.status = ST_OK;
    res.alloc_address = '0;
    case (b.opcode)
      OP_ADD: res.status = merge_region(b.region_start, b.region_size);
      OP_ALLOC: res = carve_region(b);
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          rgn_live[i] = 1'b0;
          rgn_rank[i] = 0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    out_beat_t exp_b;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        rgn_live[i] = 1'b0;
        rgn_rank[i] = 0;
      end
      floor_q = {32'd0, FLOOR_RESET};
      expected_beats.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == FLOOR_ADDR)
        floor_q = {32'd0, pwdata};
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected result beat %h", $realtime, out_data);
          fail_count++;
        end else begin
          exp_b = expected_beats.pop_front();
          if (out_data.status !== exp_b.status ||
              out_data.alloc_address !== exp_b.alloc_address) begin
            $display("%0t: mismatch expected status %0d addr %h, actual status %0d addr %h",
                     $realtime, exp_b.status, exp_b.alloc_address,
                     out_data.status, out_data.alloc_address);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) expected_beats.push_back(predict_beat(in_data));
    end
  end

endmodule

[dv/tb_top.sv]
// top of the free region table allocator testbench: clock, reset, stimulus
// and verdict; depends on fral_pkg, fral_checker and the allocator rtl
`timescale 1ns / 1ps
module tb_top;
  import fral_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_beat_t   out_data;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cycle_count;
  logic        stim_done;

  free_region_table_allocator i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  fral_checker i_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // random sink stalls
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (cycle_count % 2000 < 300) out_ready <= 1'b1;
    else out_ready <= (gap_len() == 0) ? 1'b1 : ($urandom_range(0, 2) == 0);
  end

  // valid stays up after a beat until the next call drops it or reloads it
  task automatic send_beat(op_t op, logic [63:0] start, logic [63:0] size, logic [4:0] al);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{opcode: op, region_start: start, region_size: size, align_log2: al};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_floor(logic [31:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= FLOOR_ADDR; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int count, logic [63:0] bias);
    int p;
    logic [63:0] st, sz;
    for (int k = 0; k < count; k++) begin
      p = $urandom_range(0, 99);
      st = bias + {32'd0, $urandom_range(0, 32'h00ff_ffff)};
      sz = {48'd0, 16'($urandom())};
      if (p < 40) send_beat(OP_ADD, st, sz, 5'($urandom()));
      else if (p < 55) send_beat(OP_ALLOC, 64'd0, {56'd0, 8'($urandom())},
                                 5'($urandom_range(0, 8)));
      else if (p < 80) send_beat(OP_ALLOC, 64'd0, sz >> $urandom_range(0, 12),
                                 5'($urandom()));
      else if (p < 88) send_beat(OP_ALLOC, st, sz >> 4, 5'($urandom()));
      else if (p < 92) send_beat(OP_CLEAR, rand64(), rand64(), 5'($urandom()));
      else if (p < 94) send_beat(OP_NONE, rand64(), rand64(), 5'($urandom()));
      else if (p < 97) send_beat(OP_ADD, rand64(), rand64(), 5'($urandom()));
      else send_beat(OP_ALLOC, rand64(), rand64(), 5'($urandom()));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    stim_done = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed
    send_beat(OP_ALLOC, 64'd0, 64'd16, 5'd0);
    send_beat(OP_ADD, 64'h1000, 64'h100, 5'd0);
    send_beat(OP_ADD, 64'hf_ff00, 64'h200, 5'd0);
    send_beat(OP_ADD, 64'h20_0000, 64'h1000, 5'd0);
    send_beat(OP_ADD, 64'h20_0800, 64'h1000, 5'd0);
    send_beat(OP_ADD, 64'h1f_f000, 64'h1800, 5'd0);
    send_beat(OP_ADD, 64'h1f_0000, 64'h20_0000, 5'd0);
    send_beat(OP_ALLOC, 64'd0, 64'd1, 5'd0);
    send_beat(OP_ALLOC, 64'd0, 64'd5, 5'd12);
    send_beat(OP_ALLOC, 64'h20_0100, 64'h10, 5'd31);
    send_beat(OP_ALLOC, 64'd0, 64'hffff_ffff_ffff_fffe, 5'd0);
    send_beat(OP_ALLOC, 64'd0, 64'd0, 5'd0);
    send_beat(OP_ALLOC, 64'd0, 64'h1_0000_0000, 5'd31);
    send_beat(OP_NONE, '1, '1, 5'd31);
    for (int k = 0; k < 17; k++)
      send_beat(OP_ADD, 64'h100_0000 + k * 64'h1_0000, 64'h100, 5'd0);
    send_beat(OP_ALLOC, 64'h100_0010, 64'h10, 5'd0);
    send_beat(OP_CLEAR, '0, '0, 5'd0);
    send_beat(OP_ADD, 64'hffff_ffff_ffff_f000, 64'h2000, 5'd0);
    random_phase(150, 64'h10_0000);
    write_floor(32'd0);
    send_beat(OP_ADD, 64'd0, 64'h4000, 5'd0);
    random_phase(100, 64'd0);
    write_floor(32'hffff_ffff);
    send_beat(OP_ADD, 64'hffff_0000, 64'h2_0000, 5'd0);
    random_phase(60, 64'hfff0_0000);
    write_floor(32'h0001_0000);
    random_phase(100, 64'd0);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    stim_done = 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n) cycle_count <= 0;
    else cycle_count <= cycle_count + 1;
    if (stim_done) begin
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
    end else if (cycle_count > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

[free_region_table_allocator.f]
+incdir+rtl
rtl/fral_pkg.sv
rtl/fral_ctrl.sv
rtl/fral_dp.sv
rtl/free_region_table_allocator.sv
rtl/fral_checker.sv
dv/fral_checker.sv
dv/tb_top.sv
